### sv/first_fit_partition_allocator_assert.svh
// Assertion macros for the first-fit partition allocator.
`ifndef FIRST_FIT_PARTITION_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_PARTITION_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check cons in the same cycle as ante.
`define FFPA_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ffpa assertion failed");

// Check cons in the cycle after ante.
`define FFPA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ffpa assertion failed");

`else

`define FFPA_ASSERT_NOW(label, clk, rstn, ante, cons)
`define FFPA_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

### sv/ffpa_pkg.sv
// Shared types and constants of the first-fit partition allocator.
`timescale 1ns / 1ps

package ffpa_pkg;

    localparam int SIZE_W  = 16;
    localparam int OCC_W   = 20;
    localparam int ACT_W   = 5;
    localparam int IDX_W   = 4;

    localparam logic [SIZE_W-1:0] TOTAL_RESET = 16'd2000;
    localparam logic [OCC_W-1:0]  OCC_MAX     = 20'hFFFFF;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    localparam logic REG_TOTAL  = 1'b0;
    localparam logic REG_ACTIVE = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [SIZE_W-1:0] req;
    } token_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } alloc_state_t;

endpackage

### sv/first_fit_partition_allocator.sv
// Top level of the first-fit partition allocator: control, status and cell chain.
// A load word, or an allocate word with no active partition, goes from IDLE to DONE
// and back to IDLE; any other allocate word passes through SCAN, which ends at the
// first fitting partition, or at the last active one when none fits.
// The request travels down a chain of PARTITIONS cells, one cell per cycle, and
// the first free active cell that is large enough takes it; after the scan ends,
// the DONE state registers the result word onto the m_ side.
`timescale 1ns / 1ps
`include "first_fit_partition_allocator_assert.svh"

module first_fit_partition_allocator import ffpa_pkg::*; #(
    parameter int PARTITIONS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // entry_index[3:0], size_value[19:4], zero[23:20]
    input  logic        s_tuser,    // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // granted[0], partition_number[4:1],
                                    // remaining_space[20:5], over_capacity[21], zero[23:22]
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wr_data
);

    localparam int PW  = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int CW  = $clog2(PARTITIONS + 1);
    localparam int AW  = (CW > ACT_W) ? CW : ACT_W;
    localparam int IXW = (PW > IDX_W) ? PW : IDX_W;

    logic [SIZE_W-1:0] total_reg;
    logic [ACT_W-1:0]  active_reg;
    logic [OCC_W-1:0]  occ_reg;
    logic [OCC_W-1:0]  occ_next;
    logic [PW-1:0]     count_reg;
    logic [PW-1:0]     count_next;
    logic [SIZE_W-1:0] req_reg;
    logic              launch_reg;
    logic              granted_reg;
    logic              granted_next;
    logic [IDX_W-1:0]  number_reg;
    logic [IDX_W-1:0]  number_next;
    logic              m_tvalid_reg;
    logic [23:0]       m_tdata_reg;

    alloc_state_t state_reg;
    alloc_state_t state_next;

    logic              s_func;
    logic [IDX_W-1:0]  s_index;
    logic [SIZE_W-1:0] s_size;
    logic              out_free;
    logic              accept;
    logic              scan_last;
    logic              grant_any;
    logic              flush;
    logic              capture;
    logic [CW-1:0]     n_active;
    logic [IXW-1:0]    count_ext;
    logic [OCC_W:0]    occ_sum;
    logic              over;
    logic [SIZE_W-1:0] remaining;

    logic [PARTITIONS-1:0] grant_vec;
    logic [PARTITIONS-1:0] load_vec;
    logic [PARTITIONS-1:0] active_vec;
    logic [PARTITIONS-1:0] tok_valid_vec;
    token_t                tok_chain [PARTITIONS+1];

    assign s_func  = s_tuser;
    assign s_index = s_tdata[3:0];
    assign s_size  = s_tdata[19:4];

    assign out_free  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign n_active  = (AW'(active_reg) > AW'(PARTITIONS)) ? CW'(PARTITIONS) : CW'(active_reg);
    assign scan_last = (CW'(count_reg) == (n_active - CW'(1)));
    assign grant_any = |grant_vec;
    assign count_ext = IXW'(count_reg);

    assign tok_chain[0].valid = launch_reg;
    assign tok_chain[0].req   = req_reg;

    for (genvar i = 0; i < PARTITIONS; i++) begin : g_cell
        assign load_vec[i]      = accept && (s_func == FUNC_LOAD) && (IXW'(s_index) == IXW'(i));
        assign active_vec[i]    = CW'(i) < n_active;
        assign tok_valid_vec[i] = tok_chain[i+1].valid;

        ffpa_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .load_en   (load_vec[i]),
            .load_size (s_size),
            .active    (active_vec[i]),
            .flush     (flush),
            .tok_in    (tok_chain[i]),
            .tok_out   (tok_chain[i+1]),
            .grant     (grant_vec[i])
        );
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_func == FUNC_ALLOC && n_active != '0) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (grant_any || scan_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        flush        = 1'b0;
        capture      = 1'b0;
        count_next   = count_reg;
        granted_next = granted_reg;
        number_next  = number_reg;
        occ_next     = occ_reg;
        occ_sum      = {1'b0, occ_reg} + (OCC_W+1)'(req_reg);
        case (state_reg)
            ST_IDLE: begin
                s_tready     = out_free;
                count_next   = '0;
                granted_next = 1'b0;
                number_next  = '0;
            end
            ST_SCAN: begin
                if (grant_any) begin
                    flush        = 1'b1;
                    granted_next = 1'b1;
                    number_next  = count_ext[IDX_W-1:0];
                    occ_next     = occ_sum[OCC_W] ? OCC_MAX : occ_sum[OCC_W-1:0];
                end else if (scan_last) begin
                    flush = 1'b1;
                end else begin
                    count_next = count_reg + PW'(1);
                end
            end
            ST_DONE: begin
                capture = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign over      = occ_reg > OCC_W'(total_reg);
    assign remaining = over ? '0 : (total_reg - occ_reg[SIZE_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            total_reg    <= TOTAL_RESET;
            active_reg   <= '0;
            occ_reg      <= '0;
            launch_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            launch_reg <= accept && (s_func == FUNC_ALLOC) && (n_active != '0);
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_TOTAL:  total_reg  <= cfg_wr_data;
                    REG_ACTIVE: active_reg <= cfg_wr_data[ACT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (capture) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        count_reg   <= count_next;
        granted_reg <= granted_next;
        number_reg  <= number_next;
        if (accept) begin
            req_reg <= s_size;
        end
        if (capture) begin
            m_tdata_reg <= {2'b00, over, remaining, number_reg, granted_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `FFPA_ASSERT_NOW(a_one_grant, aclk, aresetn, 1'b1, $onehot0(grant_vec))
    `FFPA_ASSERT_NOW(a_one_token, aclk, aresetn, 1'b1, $onehot0({tok_valid_vec, launch_reg}))
    `FFPA_ASSERT_NOW(a_scan_out_empty, aclk, aresetn, state_reg == ST_SCAN, !m_tvalid_reg)
    `FFPA_ASSERT_NEXT(a_flush_done, aclk, aresetn, flush, state_reg == ST_DONE && tok_valid_vec == '0)

endmodule

### sv/ffpa_cell.sv
// One partition cell: holds size and busy mark, checks the passing request.
`timescale 1ns / 1ps

module ffpa_cell import ffpa_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load_en,
    input  logic [SIZE_W-1:0] load_size,
    input  logic              active,
    input  logic              flush,
    input  token_t            tok_in,
    output token_t            tok_out,
    output logic              grant
);

    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] size_next;
    logic              busy_reg;
    logic              busy_next;
    token_t            tok_reg;
    token_t            tok_next;

    assign grant = tok_in.valid && active && !busy_reg && (size_reg >= tok_in.req);

    always_comb begin
        size_next = size_reg;
        busy_next = busy_reg;
        if (load_en) begin
            size_next = load_size;
            busy_next = 1'b0;
        end else if (grant) begin
            busy_next = 1'b1;
        end
        tok_next.valid = tok_in.valid && !grant && !flush;
        tok_next.req   = tok_in.req;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg      <= '0;
            busy_reg      <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else begin
            size_reg      <= size_next;
            busy_reg      <= busy_next;
            tok_reg.valid <= tok_next.valid;
        end
        tok_reg.req <= tok_next.req;
    end

    assign tok_out = tok_reg;

endmodule
